// ----- rtl/ulc_pkg.sv -----
package ulc_pkg;

	localparam int MAX_LINES_DEF      = 64;
	localparam int MAX_SAMPLES_DEF    = 2048;
	localparam int LOG_TABLE_BITS_DEF = 6;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 12;

	localparam logic [CFG_INDEX_W-1:0] REG_DYN_RANGE   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_EDGE_MARGIN = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SAMPLES     = 2'd2;

	localparam logic [6:0]  DYN_RANGE_RST   = 7'd60;
	localparam logic [9:0]  EDGE_MARGIN_RST = 10'd128;
	localparam logic [11:0] SAMPLES_RST     = 12'd2048;

	localparam logic CMD_STORE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	// 255 * 20*log10(2) in q16
	localparam logic [26:0] GAIN_K = 27'd100614330;

	localparam int LOG_W = 20;

	typedef struct packed {
		logic        cmd;
		logic        frame_start;
		logic [5:0]  line_index;
		logic [10:0] sample_index;
		logic [15:0] sample_value;
		logic [8:0]  ring_index;
	} item_t;

	typedef struct packed {
		logic [7:0] gray_level;
		logic [9:0] ring_radius;
	} result_t;

	typedef struct packed {
		logic        start;
		logic [15:0] dividend;
		logic [6:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic [15:0] quotient;
	} div_rsp_t;

	function automatic logic [15:0] log2_frac_entry(input int idx, input int tbl_bits);
		logic [63:0] m;
		logic [15:0] r;
		m = (64'd1 << 30) + (64'(idx) << (30 - tbl_bits));
		r = 16'd0;
		for (int k = 0; k < 16; k++) begin
			m = (m * m) >> 30;
			r = {r[14:0], 1'b0};
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				r[0] = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

// ----- rtl/ulc_frame_mem.sv -----
module ulc_frame_mem #(
	parameter int AW = 17
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [15:0]   wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [15:0]   rd_data
);

	logic [15:0] mem [1 << AW];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/ulc_log.sv -----
module ulc_log #(
	parameter int TBL_BITS = 6
) (
	input  logic                 clk,
	input  logic [15:0]          x,
	output logic [ulc_pkg::LOG_W-1:0] l
);

	import ulc_pkg::*;

	localparam int TBL_SIZE = 1 << TBL_BITS;

	logic [15:0]         frac_tbl [TBL_SIZE];
	logic [3:0]          p;
	logic [15:0]         y;
	logic [3:0]          p_s1;
	logic [TBL_BITS-1:0] f_s1;
	logic [LOG_W-1:0]    l_s2;

	for (genvar i = 0; i < TBL_SIZE; i++) begin : g_tbl
		localparam logic [15:0] ENTRY = log2_frac_entry(i, TBL_BITS);
		assign frac_tbl[i] = ENTRY;
	end

	// leading-one position and normalized word
	always_comb begin
		p = 4'd0;
		for (int i = 0; i < 16; i++) begin
			if (x[i]) begin
				p = 4'(i);
			end
		end
		y = x << (4'd15 - p);
	end

	always_ff @(posedge clk) begin
		p_s1 <= p;
		f_s1 <= y[14 -: TBL_BITS];
		l_s2 <= {p_s1, frac_tbl[f_s1]};
	end

	assign l = l_s2;

endmodule

// ----- rtl/ulc_div.sv -----
module ulc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  ulc_pkg::div_req_t req,
	output ulc_pkg::div_rsp_t rsp
);

	import ulc_pkg::*;

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [6:0]  rem_q;
	logic [15:0] quo_q;
	logic [6:0]  divisor_q;
	logic [7:0]  rem_sh;
	logic        take;

	assign rem_sh = {rem_q, quo_q[15]};
	assign take   = rem_sh >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'd16;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= 7'd0;
			quo_q     <= req.dividend;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= take ? 7'(rem_sh - {1'b0, divisor_q}) : rem_sh[6:0];
			quo_q <= {quo_q[14:0], take};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.quotient = quo_q;

endmodule

// ----- rtl/ultrasound_log_compression.sv -----
// B-mode log compression. A store transaction (cmd 0) writes one 16-bit envelope
// sample into the frame store and updates the running frame maximum in the same
// cycle, so stores are taken back to back at one per cycle while no read is in
// progress. A read transaction (cmd 1) fetches one sample and converts it to an
// 8-bit gray level. item_stall is high from the accept of a read through the frame
// store read, the log2 units, the gain multiply, the start of the divide, the
// 16-step bit-serial divide by the dynamic range and the load of the output
// register, so no further transaction is taken while a read is in progress. The
// result sits in an output register, so the next transaction is taken while it
// waits to be consumed; a read that finishes while an earlier result still waits
// holds item_stall high until that result is taken.
// The frame store has no reset; only written entries may be read.
module ultrasound_log_compression #(
	parameter int MAX_LINES      = ulc_pkg::MAX_LINES_DEF,
	parameter int MAX_SAMPLES    = ulc_pkg::MAX_SAMPLES_DEF,
	parameter int LOG_TABLE_BITS = ulc_pkg::LOG_TABLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  ulc_pkg::item_t                   item,
	output logic                             result_valid,
	input  logic                             result_stall,
	output ulc_pkg::result_t                 result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ulc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [ulc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	import ulc_pkg::*;

	localparam int SW  = $clog2(MAX_SAMPLES);
	localparam int LW  = MAX_LINES > 1 ? $clog2(MAX_LINES) : 1;
	localparam int AW  = LW + SW;
	localparam int SLW = $clog2(MAX_SAMPLES + 1);
	localparam int CW  = (SLW > 12 ? SLW : 12) + 1;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MEM  = 7'b0000010,
		ST_LOG1 = 7'b0000100,
		ST_LOG2 = 7'b0001000,
		ST_MUL  = 7'b0010000,
		ST_DIV  = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	state_t state_q;

	logic [6:0]  dyn_range_q;
	logic [9:0]  edge_margin_q;
	logic [11:0] samples_q;
	logic [15:0] frame_max_q;

	logic          accept;
	logic          is_store;
	logic          is_read;
	logic [CW-1:0] slen;
	logic [CW-1:0] rings;
	logic [CW-1:0] sidx_w;
	logic [CW-1:0] ring_w;
	logic [CW-1:0] em_w;
	logic [CW-1:0] pos;
	logic          line_ok;
	logic          sidx_ok;
	logic          ring_ok;
	logic          in_window;
	logic [15:0]   max_base;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [15:0]   rd_data;

	logic             live_q;
	logic             zero_q;
	logic             sat_q;
	logic [9:0]       radius_q;
	logic [LOG_W-1:0] l_max;
	logic [LOG_W-1:0] l_val;
	logic [LOG_W-1:0] d;
	logic [47:0]      prod_q;
	logic [47:0]      rounded;
	logic [6:0]       r_eff;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic       out_load;
	logic [7:0] gray;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dyn_range_q   <= DYN_RANGE_RST;
			edge_margin_q <= EDGE_MARGIN_RST;
			samples_q     <= SAMPLES_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DYN_RANGE:   dyn_range_q   <= cfg_data[6:0];
				REG_EDGE_MARGIN: edge_margin_q <= cfg_data[9:0];
				REG_SAMPLES:     samples_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign item_stall = state_q != ST_IDLE;
	assign accept     = item_valid && !item_stall;
	assign is_store   = accept && item.cmd == CMD_STORE;
	assign is_read    = accept && item.cmd == CMD_READ;

	// address and window arithmetic
	assign slen   = (CW'(samples_q) < CW'(MAX_SAMPLES)) ? CW'(samples_q) : CW'(MAX_SAMPLES);
	assign rings  = slen >> 2;
	assign sidx_w = CW'(item.sample_index);
	assign ring_w = CW'(item.ring_index);
	assign em_w   = CW'(edge_margin_q);
	assign pos    = slen - CW'(1) - (ring_w << 2);

	assign line_ok   = 9'(item.line_index) < 9'(MAX_LINES);
	assign sidx_ok   = sidx_w < CW'(MAX_SAMPLES);
	assign ring_ok   = ring_w < rings;
	assign in_window = sidx_w >= em_w && (sidx_w + em_w) < slen;
	assign max_base  = item.frame_start ? 16'd0 : frame_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_max_q <= 16'd0;
		end else if (is_store) begin
			if (line_ok && sidx_ok && in_window && item.sample_value > max_base) begin
				frame_max_q <= item.sample_value;
			end else begin
				frame_max_q <= max_base;
			end
		end
	end

	assign wr_en   = is_store && line_ok && sidx_ok;
	assign wr_addr = {LW'(item.line_index), SW'(item.sample_index)};
	assign rd_addr = {LW'(item.line_index), SW'(pos)};

	ulc_frame_mem #(
		.AW(AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (item.sample_value),
		.rd_en   (is_read),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	ulc_log #(
		.TBL_BITS(LOG_TABLE_BITS)
	) u_log_max (
		.clk (clk),
		.x   (frame_max_q),
		.l   (l_max)
	);

	ulc_log #(
		.TBL_BITS(LOG_TABLE_BITS)
	) u_log_val (
		.clk (clk),
		.x   (rd_data),
		.l   (l_val)
	);

	always_ff @(posedge clk) begin
		if (is_read) begin
			live_q   <= line_ok && ring_ok;
			radius_q <= ring_ok ? 10'(rings - ring_w) : 10'd0;
		end
		if (state_q == ST_MEM) begin
			zero_q <= rd_data == 16'd0;
			sat_q  <= rd_data >= frame_max_q;
		end
		if (state_q == ST_LOG2) begin
			prod_q <= 48'(d) * 48'(GAIN_K);
		end
	end

	assign d       = l_max - l_val;
	assign r_eff   = (dyn_range_q == 7'd0) ? 7'd1 : dyn_range_q;
	assign rounded = prod_q + (48'(r_eff) << 31);

	assign div_req.start    = state_q == ST_MUL;
	assign div_req.dividend = rounded[47:32];
	assign div_req.divisor  = r_eff;

	ulc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		if (!live_q || zero_q) begin
			gray = 8'd0;
		end else if (sat_q) begin
			gray = 8'd255;
		end else if (div_rsp.quotient >= 16'd255) begin
			gray = 8'd0;
		end else begin
			gray = 8'(16'd255 - div_rsp.quotient);
		end
	end

	assign out_load = state_q == ST_FIN && (!result_valid || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (is_read) begin
						state_q <= ST_MEM;
					end
				end
				ST_MEM:  state_q <= ST_LOG1;
				ST_LOG1: state_q <= ST_LOG2;
				ST_LOG2: state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_DIV;
				ST_DIV: begin
					if (!div_rsp.busy) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_load) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result.gray_level  <= gray;
			result.ring_radius <= radius_q;
		end
	end

endmodule

// ----- dv/ultrasound_log_compression_tb.sv -----
`timescale 1ns / 100ps

module ultrasound_log_compression_tb;
	import ulc_pkg::*;

	localparam int MEM_DEPTH = MAX_LINES_DEF * MAX_SAMPLES_DEF;
	localparam int LUT_BITS = LOG_TABLE_BITS_DEF;
	localparam longint unsigned DB_PER_OCTAVE_Q16 = 64'd394566;
	localparam int DRAIN_CYCLES = 40;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 226;

	typedef struct packed {
		logic [6:0]  range_db;
		logic [9:0]  margin;
		logic [11:0] samples;
	} scan_cfg_t;

	typedef enum logic {ROW_ITEM, ROW_SETUP} row_kind_t;

	typedef struct {
		row_kind_t kind;
		item_t     it;
		logic      known;
		result_t   want;
		scan_cfg_t cfg;
	} probe_row_t;

	typedef struct packed {
		logic [5:0] line;
		logic [8:0] ring;
	} spot_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item_d = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t pixel;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predictor state
	logic [15:0] envelope_mem [MEM_DEPTH];
	bit mem_written [MEM_DEPTH];
	logic [15:0] peak_level = '0;
	logic [6:0] range_db_cfg = DYN_RANGE_RST;
	logic [9:0] margin_cfg = EDGE_MARGIN_RST;
	logic [11:0] samples_cfg = SAMPLES_RST;
	logic [15:0] frac_lut [1 << LUT_BITS];

	result_t pending_pixels[$];
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles = 0;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_req = 0;
	int unsigned hold_left = 0;

	probe_row_t probes[$];
	scan_cfg_t plan [8] = '{
		'{7'd60, 10'd128, 12'd2048},
		'{7'd1, 10'd0, 12'd8},
		'{7'd120, 10'd1023, 12'd2048},
		'{7'd127, 10'd3, 12'd4095},
		'{7'd0, 10'd64, 12'd1001},
		'{7'd40, 10'd500, 12'd1024},
		'{7'd60, 10'd1, 12'd12},
		'{7'd20, 10'd200, 12'd2048}
	};

	ultrasound_log_compression u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item_d),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(pixel),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [15:0] frac_log2(input int unsigned i);
		logic [63:0] m;
		logic [15:0] q;
		m = (64'd1 << 30) + (64'(i) << (30 - LUT_BITS));
		q = '0;
		for (int k = 0; k < 16; k++) begin
			m = (m * m) >> 30;
			q = {q[14:0], 1'b0};
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [31:0] log2_fixed(input logic [15:0] x);
		int unsigned p;
		logic [LUT_BITS-1:0] f;
		p = 0;
		for (int b = 0; b < 16; b++)
			if (x[b])
				p = b;
		if (p >= LUT_BITS)
			f = LUT_BITS'(x >> (p - LUT_BITS));
		else
			f = LUT_BITS'(x << (LUT_BITS - p));
		return (32'(p) << 16) + 32'(frac_lut[f]);
	endfunction

	function automatic int unsigned eff_len();
		return (samples_cfg < MAX_SAMPLES_DEF) ? int'(samples_cfg) : MAX_SAMPLES_DEF;
	endfunction

	function automatic logic [7:0] gray_of(input logic [15:0] v, input logic [15:0] mx);
		logic [31:0] diff;
		logic [63:0] d, den, sub;
		if (v == 0)
			return 8'd0;
		if (v >= mx)
			return 8'd255;
		diff = log2_fixed(mx) - log2_fixed(v);
		d = 64'(diff);
		den = 64'((range_db_cfg == 0) ? 7'd1 : range_db_cfg) << 32;
		sub = (64'd255 * d * DB_PER_OCTAVE_Q16 + den / 2) / den;
		return (sub >= 255) ? 8'd0 : 8'(255 - sub);
	endfunction

	// updates the frame state; returns 1 with the pixel for a read
	function automatic bit predict_pixel(input item_t it, output result_t px);
		int unsigned slen, rings, pos;
		logic [16:0] addr;
		px = '0;
		slen = eff_len();
		if (it.cmd == CMD_STORE) begin
			if (it.frame_start)
				peak_level = '0;
			addr = {it.line_index, it.sample_index};
			envelope_mem[addr] = it.sample_value;
			mem_written[addr] = 1'b1;
			if (it.sample_index >= margin_cfg && it.sample_index + margin_cfg < slen &&
			    it.sample_value > peak_level)
				peak_level = it.sample_value;
			return 1'b0;
		end
		rings = slen / 4;
		if (it.ring_index < rings) begin
			pos = slen - 1 - 4 * it.ring_index;
			px.ring_radius = 10'(rings - it.ring_index);
			px.gray_level = gray_of(envelope_mem[{it.line_index, 11'(pos)}], peak_level);
		end
		return 1'b1;
	endfunction

	function automatic bit can_read(input item_t it);
		int unsigned slen;
		slen = eff_len();
		if (it.ring_index >= slen / 4)
			return 1'b1;
		return mem_written[{it.line_index, 11'(slen - 1 - 4 * it.ring_index)}];
	endfunction

	function automatic item_t random_item();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(item_t)-1:0];
	endfunction

	function automatic logic [15:0] pick_amplitude();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 8)
			return 16'd0;
		if (roll < 16)
			return 16'hFFFF;
		if (roll < 40)
			return 16'($urandom_range(255, 1));
		return 16'($urandom);
	endfunction

	function automatic probe_row_t store_row(input int line, input int sidx, input int val,
			input bit fs);
		probe_row_t r;
		r = '{kind: ROW_ITEM, it: '0, known: 1'b0, want: '0, cfg: '0};
		r.it.cmd = CMD_STORE;
		r.it.frame_start = fs;
		r.it.line_index = 6'(line);
		r.it.sample_index = 11'(sidx);
		r.it.sample_value = 16'(val);
		return r;
	endfunction

	function automatic probe_row_t read_row(input int line, input int ring);
		probe_row_t r;
		r = '{kind: ROW_ITEM, it: '0, known: 1'b0, want: '0, cfg: '0};
		r.it.cmd = CMD_READ;
		r.it.line_index = 6'(line);
		r.it.ring_index = 9'(ring);
		return r;
	endfunction

	function automatic probe_row_t read_row_known(input int line, input int ring, input bit fs,
			input int gray, input int radius);
		probe_row_t r;
		r = read_row(line, ring);
		r.it.frame_start = fs;
		r.known = 1'b1;
		r.want.gray_level = 8'(gray);
		r.want.ring_radius = 10'(radius);
		return r;
	endfunction

	function automatic probe_row_t setup_row(input int range_db, input int margin,
			input int samples);
		probe_row_t r;
		r = '{kind: ROW_SETUP, it: '0, known: 1'b0, want: '0, cfg: '0};
		r.cfg = '{7'(range_db), 10'(margin), 12'(samples)};
		return r;
	endfunction

	task automatic send_item(input item_t it, input logic known, input result_t want);
		bit taken;
		result_t px;
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item_d <= it;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !item_stall;
			if (taken && predict_pixel(it, px))
				pending_pixels.push_back(known ? want : px);
			@(posedge clk);
		end
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		bit done;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		done = 1'b0;
		while (!done) begin
			@(negedge clk);
			done = cfg_ready;
			@(posedge clk);
		end
	endtask

	task automatic program_regs(input scan_cfg_t c);
		write_reg(REG_DYN_RANGE, CFG_DATA_W'(c.range_db));
		write_reg(REG_EDGE_MARGIN, CFG_DATA_W'(c.margin));
		write_reg(REG_SAMPLES, c.samples);
		cfg_valid <= 1'b0;
		range_db_cfg = c.range_db;
		margin_cfg = c.margin;
		samples_cfg = c.samples;
	endtask

	// frame start, stores mostly on ring positions, then reads mostly of those
	task automatic run_burst(inout int unsigned sent);
		spot_t spots[$];
		logic [5:0] lines [4];
		item_t it;
		int unsigned slen, rings, n_store, n_read, j;
		slen = eff_len();
		rings = slen / 4;
		foreach (lines[i])
			lines[i] = 6'($urandom_range(63));
		n_store = $urandom_range(24, 4);
		n_read = $urandom_range(24, 4);
		for (int k = 0; k < n_store; k++) begin
			it = random_item();
			it.cmd = CMD_STORE;
			it.frame_start = (k == 0) || ($urandom_range(99) < 3);
			it.line_index = lines[$urandom_range(3)];
			it.sample_value = pick_amplitude();
			if (rings != 0 && $urandom_range(99) < 80) begin
				j = $urandom_range(rings - 1);
				it.sample_index = 11'(slen - 1 - 4 * j);
				spots.push_back('{it.line_index, 9'(j)});
			end
			send_item(it, 1'b0, '0);
		end
		for (int k = 0; k < n_read; k++) begin
			it = random_item();
			it.cmd = CMD_READ;
			if (spots.size() != 0 && $urandom_range(99) < 70) begin
				j = $urandom_range(spots.size() - 1);
				it.line_index = spots[j].line;
				it.ring_index = spots[j].ring;
			end
			if (!can_read(it)) begin
				if (rings < 512) begin
					it.ring_index = 9'($urandom_range(511, rings));
				end else if (spots.size() != 0) begin
					j = $urandom_range(spots.size() - 1);
					it.line_index = spots[j].line;
					it.ring_index = spots[j].ring;
				end else begin
					it.cmd = CMD_STORE;
				end
			end
			send_item(it, 1'b0, '0);
		end
		sent += n_store + n_read;
	endtask

	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(negedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_pixels.size() == 0) begin
				$error("unexpected transaction: gray_level %0d ring_radius %0d",
				       pixel.gray_level, pixel.ring_radius);
				mismatch_count++;
			end else begin
				want = pending_pixels.pop_front();
				if (pixel.gray_level !== want.gray_level) begin
					$error("gray_level: expected %0d, actual %0d", want.gray_level, pixel.gray_level);
					mismatch_count++;
				end
				if (pixel.ring_radius !== want.ring_radius) begin
					$error("ring_radius: expected %0d, actual %0d", want.ring_radius,
					       pixel.ring_radius);
					mismatch_count++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall) ||
		    (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int unsigned phase_sent;
		foreach (frac_lut[i])
			frac_lut[i] = frac_log2(i);
		probes = '{
			store_row(0, 2047, 0, 1),
			read_row_known(0, 0, 0, 0, 512),
			store_row(63, 1919, 65535, 0),
			read_row_known(63, 32, 0, 255, 480),
			store_row(5, 3, 1, 0),
			read_row(5, 511),
			store_row(5, 1023, 256, 0),
			read_row(5, 256),
			store_row(10, 0, 5, 1),
			read_row_known(5, 511, 0, 255, 1),
			store_row(10, 127, 40000, 0),
			store_row(10, 128, 300, 0),
			store_row(10, 1919, 50000, 0),
			store_row(10, 1920, 60000, 0),
			store_row(10, 1923, 25000, 0),
			read_row(10, 31),
			read_row_known(10, 32, 1, 255, 480),
			setup_row(60, 128, 8),
			read_row_known(0, 2, 0, 0, 0),
			store_row(0, 7, 1000, 0),
			read_row(0, 0),
			setup_row(0, 128, 8),
			read_row(0, 0),
			setup_row(120, 1023, 4095),
			read_row(10, 31),
			store_row(1, 1023, 7, 1),
			store_row(1, 1024, 9, 0),
			read_row_known(10, 32, 0, 255, 480)
		};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 38;
		stall_pct = 38;
		foreach (probes[i]) begin
			if (probes[i].kind == ROW_SETUP) begin
				settle();
				program_regs(probes[i].cfg);
			end else begin
				send_item(probes[i].it, probes[i].known, probes[i].want);
			end
		end
		for (int p = 0; p < 8; p++) begin
			settle();
			program_regs(plan[p]);
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 71;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 71;
				end
				default: begin
					send_idle_pct = 38;
					stall_pct = 38;
				end
			endcase
			if (p == 0)
				hold_req = HOLD_CYCLES;
			phase_sent = 0;
			while (phase_sent < PHASE_ITEMS)
				run_burst(phase_sent);
		end
		settle();
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/ulc_pkg.sv
rtl/ulc_frame_mem.sv
rtl/ulc_log.sv
rtl/ulc_div.sv
rtl/ultrasound_log_compression.sv
dv/ultrasound_log_compression_tb.sv
